// ----- hdl/api_pkg.sv -----
package api_pkg;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    localparam logic [2:0] ST_NORMAL  = 3'd0;
    localparam logic [2:0] ST_JUMP    = 3'd1;
    localparam logic [2:0] ST_ADVANCE = 3'd2;
    localparam logic [2:0] ST_WAIT    = 3'd3;
    localparam logic [2:0] ST_DROP    = 3'd4;

    localparam logic CFG_GAIN = 1'b0;
    localparam logic CFG_FILL = 1'b1;

    localparam int FRAC_STEPS = 17;

    typedef enum logic [1:0] {
        RS_FIRST,
        RS_NEXT,
        RS_LAST,
        RS_JUMP
    } rsel_t;

    typedef struct packed {
        logic       latch;
        logic       push;
        logic       pop;
        logic       clear;
        logic       cap_v;
        logic       cap_first;
        logic       cap_next;
        logic       cap_last;
        logic       cap_jump;
        logic       fix_half;
        logic       div_init;
        logic       div_step;
        logic       et_init;
        logic       et_step;
        logic       mul_sq;
        logic       mul_cu;
        logic       mul_rt;
        logic       mul_dl;
        logic       apply;
        logic       load_out;
        rsel_t      rsel;
        logic [2:0] code;
    } ctrl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       full;
        logic       lt2;
        logic       same;
        logic       outside;
        logic       short2t;
        logic       past_next;
        logic       fix_needed;
    } stat_t;

endpackage

// ----- hdl/adaptive_playout_interpolator_top.sv -----
// Jitter-buffer playout controller. One command beat in (push, pop, clear or
// tick) gives one result beat out. A tick with fewer than two stamps does not
// read the buffer; a tick that interpolates runs the stamp reads, which go
// through the single read port of the stamp RAM one at a time, then a
// 17-step fraction divider, the fill-error divider by target_fill (23 steps
// at the default depth), and four registered multiplies. A finished result
// waits in the output register while the next command is taken. Stamp RAM
// contents are undefined after reset; only entries that were pushed are read.
module adaptive_playout_interpolator_top #(
    parameter int BUFFER_DEPTH = 32,
    parameter int TIME_BITS    = 48
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic                               cfg_index,
    input  logic [15:0]                        cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         command,
    input  logic [TIME_BITS-1:0]               stamp_time,
    input  logic [TIME_BITS-1:0]               wall_time,
    input  logic [15:0]                        tick_step,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [2:0]                         status,
    output logic [16:0]                        blend_fraction,
    output logic signed [TIME_BITS-1:0]        time_offset,
    output logic [$clog2(BUFFER_DEPTH+1)-1:0]  fill_count
);

    import api_pkg::*;

    localparam int CLOG = $clog2(BUFFER_DEPTH + 1);
    localparam int EW   = ((CLOG > 5) ? CLOG : 5) + 17;

    ctrl_t ctrl;
    stat_t stat;

    api_ctrl #(
        .ESTEPS (EW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    api_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .TIME_BITS    (TIME_BITS),
        .EW           (EW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .stat           (stat),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .command        (command),
        .stamp_time     (stamp_time),
        .wall_time      (wall_time),
        .tick_step      (tick_step),
        .status         (status),
        .blend_fraction (blend_fraction),
        .time_offset    (time_offset),
        .fill_count     (fill_count)
    );

endmodule

// ----- hdl/api_ram.sv -----
module api_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/api_dp.sv -----
module api_dp #(
    parameter int BUFFER_DEPTH = 32,
    parameter int TIME_BITS    = 48,
    parameter int EW           = 23
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  api_pkg::ctrl_t                     ctrl,
    output api_pkg::stat_t                     stat,
    input  logic                               cfg_write,
    input  logic                               cfg_index,
    input  logic [15:0]                        cfg_data,
    input  logic [1:0]                         command,
    input  logic [TIME_BITS-1:0]               stamp_time,
    input  logic [TIME_BITS-1:0]               wall_time,
    input  logic [15:0]                        tick_step,
    output logic [2:0]                         status,
    output logic [16:0]                        blend_fraction,
    output logic signed [TIME_BITS-1:0]        time_offset,
    output logic [$clog2(BUFFER_DEPTH+1)-1:0]  fill_count
);

    import api_pkg::*;

    localparam int TE  = (TIME_BITS > 62) ? 62 : TIME_BITS;
    localparam int AB  = $clog2(BUFFER_DEPTH);
    localparam int CB  = $clog2(BUFFER_DEPTH + 1);
    localparam int SQW = 2 * EW - 16;
    localparam int CUW = 3 * EW - 32;
    localparam int RTW = CUW + 8;
    localparam int XW  = (TE + 4 > RTW + 2) ? TE + 4 : RTW + 2;

    localparam logic [AB:0] DEPTH_W = (AB + 1)'(BUFFER_DEPTH);
    localparam logic [CB-1:0] FULL_W = CB'(BUFFER_DEPTH);
    localparam logic signed [XW-1:0] OMAX = $signed({{(XW - TE + 1){1'b0}}, {(TE - 1){1'b1}}});
    localparam logic signed [XW-1:0] OMIN = ~OMAX;

    logic [15:0]             gain_reg;
    logic [4:0]              tfill_reg;
    logic [1:0]              cmd_reg;
    logic [TE-1:0]           stamp_reg;
    logic [TE-1:0]           wall_reg;
    logic [15:0]             step_reg;
    logic [AB-1:0]           rp_reg;
    logic [CB-1:0]           held_reg;
    logic signed [TE-1:0]    off_reg;
    logic [16:0]             frac_reg;
    logic signed [XW-1:0]    v_reg;
    logic [TE-1:0]           first_reg;
    logic [TE-1:0]           next_reg;
    logic [TE-1:0]           last_reg;
    logic [TE:0]             rem_reg;
    logic [16:0]             q_reg;
    logic                    neg_reg;
    logic [EW-1:0]           eq_reg;
    logic [4:0]              erem_reg;
    logic [SQW-1:0]          sq_reg;
    logic [CUW-1:0]          cu_reg;
    logic [RTW-1:0]          rt_reg;
    logic [RTW-1:0]          dl_reg;
    logic [2:0]              ostat_reg;
    logic [16:0]             ofrac_reg;
    logic signed [TE-1:0]    ooff_reg;
    logic [CB-1:0]           ofill_reg;

    logic [TIME_BITS-1:0]    rdata;
    logic [AB-1:0]           waddr;
    logic [AB-1:0]           raddr;
    logic [CB-1:0]           rk;
    logic [4:0]              tv;
    logic signed [XW-1:0]    off_x;
    logic signed [XW-1:0]    wall_x;
    logic signed [XW-1:0]    first_x;
    logic signed [XW-1:0]    next_x;
    logic signed [XW-1:0]    last_x;
    logic signed [XW-1:0]    jump_x;
    logic signed [XW-1:0]    pw_x;
    logic signed [XW-1:0]    d_x;
    logic signed [XW-1:0]    fix_x;
    logic signed [XW-1:0]    add_x;
    logic [TE:0]             den;
    logic                    ge;
    logic [TE:0]             rem_sub;
    logic signed [EW:0]      en;
    logic [EW-1:0]           m;
    logic [5:0]              trial;
    logic [2*EW-1:0]         p1;
    logic [EW+SQW-1:0]       p2;
    logic [CUW+15:0]         p3;
    logic [RTW+15:0]         p4;

    function automatic logic [AB-1:0] wrap(input logic [AB:0] s);
        logic [AB:0] r;
        r = (s >= DEPTH_W) ? s - DEPTH_W : s;
        return r[AB-1:0];
    endfunction

    function automatic logic signed [TE-1:0] sat(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] r;
        r = (x > OMAX) ? OMAX : ((x < OMIN) ? OMIN : x);
        return r[TE-1:0];
    endfunction

    assign tv = (tfill_reg == 5'd0) ? 5'd1 : tfill_reg;

    assign off_x   = XW'(off_reg);
    assign wall_x  = $signed(XW'(wall_reg));
    assign first_x = $signed(XW'(first_reg));
    assign next_x  = $signed(XW'(next_reg));
    assign last_x  = $signed(XW'(last_reg));
    assign jump_x  = $signed(XW'(rdata[TE-1:0])) - wall_x;
    assign pw_x    = off_x + wall_x;
    assign d_x     = next_x - pw_x;
    // halve toward zero
    assign fix_x   = off_x + ((d_x + $signed({{(XW - 1){1'b0}}, d_x[XW-1]})) >>> 1);
    assign add_x   = neg_reg ? off_x - $signed(XW'(dl_reg)) : off_x + $signed(XW'(dl_reg));

    always_comb
    begin
        case (ctrl.rsel)
            RS_FIRST: rk = '0;
            RS_NEXT:  rk = CB'(1);
            RS_LAST:  rk = held_reg - CB'(1);
            RS_JUMP:  rk = held_reg - CB'(1) - CB'(tv);
            default:  rk = '0;
        endcase
    end

    assign raddr = wrap({1'b0, rp_reg} + (AB + 1)'(rk));
    assign waddr = wrap({1'b0, rp_reg} + (AB + 1)'(held_reg));

    api_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ctrl.push),
        .waddr (waddr),
        .wdata (TIME_BITS'(stamp_reg)),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign den     = (TE + 1)'(next_reg - first_reg);
    assign ge      = rem_reg >= den;
    assign rem_sub = ge ? rem_reg - den : rem_reg;

    assign en = $signed((EW + 1)'({held_reg, 16'b0})) - $signed((EW + 1)'(q_reg))
              - $signed((EW + 1)'({tv, 16'b0}));
    assign m  = en[EW] ? EW'(-en) : EW'(en);
    assign trial = {erem_reg, eq_reg[EW-1]};

    assign p1 = eq_reg * eq_reg;
    assign p2 = eq_reg * sq_reg;
    assign p3 = cu_reg * gain_reg;
    assign p4 = rt_reg * step_reg;

    assign stat.cmd        = cmd_reg;
    assign stat.full       = held_reg == FULL_W;
    assign stat.lt2        = held_reg < CB'(2);
    assign stat.same       = first_reg == next_reg;
    assign stat.outside    = (v_reg > last_x) || (v_reg < first_x);
    assign stat.short2t    = 10'(held_reg) < {4'b0, tv, 1'b0};
    assign stat.past_next  = v_reg > next_x;
    assign stat.fix_needed = !(v_reg > last_x) && (pw_x < first_x);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= 16'd1280;
            tfill_reg <= 5'd5;
            rp_reg    <= '0;
            held_reg  <= '0;
            off_reg   <= '0;
            frac_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_GAIN: gain_reg  <= cfg_data;
                    CFG_FILL: tfill_reg <= cfg_data[4:0];
                    default:  gain_reg  <= gain_reg;
                endcase
            end
            if (ctrl.push)
            begin
                held_reg <= held_reg + CB'(1);
            end
            if (ctrl.pop && held_reg != '0)
            begin
                rp_reg   <= wrap({1'b0, rp_reg} + (AB + 1)'(1));
                held_reg <= held_reg - CB'(1);
            end
            if (ctrl.clear)
            begin
                rp_reg   <= '0;
                held_reg <= '0;
            end
            if (ctrl.cap_jump)
            begin
                off_reg <= sat(jump_x);
            end
            if (ctrl.fix_half)
            begin
                off_reg <= sat(fix_x);
            end
            if (ctrl.et_init)
            begin
                frac_reg <= q_reg;
            end
            if (ctrl.apply)
            begin
                off_reg <= sat(add_x);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            cmd_reg   <= command;
            stamp_reg <= stamp_time[TE-1:0];
            wall_reg  <= wall_time[TE-1:0];
            step_reg  <= tick_step;
        end
        if (ctrl.cap_v)
        begin
            v_reg <= wall_x + off_x;
        end
        if (ctrl.cap_first)
        begin
            first_reg <= rdata[TE-1:0];
        end
        if (ctrl.cap_next)
        begin
            next_reg <= rdata[TE-1:0];
        end
        if (ctrl.cap_last)
        begin
            last_reg <= rdata[TE-1:0];
        end
        if (ctrl.div_init)
        begin
            rem_reg <= (TE + 1)'(v_reg - first_x);
            q_reg   <= '0;
        end
        if (ctrl.div_step)
        begin
            q_reg   <= {q_reg[15:0], ge};
            rem_reg <= {rem_sub[TE-1:0], 1'b0};
        end
        if (ctrl.et_init)
        begin
            neg_reg  <= en[EW];
            eq_reg   <= m;
            erem_reg <= '0;
        end
        if (ctrl.et_step)
        begin
            if (trial >= {1'b0, tv})
            begin
                erem_reg <= 5'(trial - {1'b0, tv});
                eq_reg   <= {eq_reg[EW-2:0], 1'b1};
            end
            else
            begin
                erem_reg <= trial[4:0];
                eq_reg   <= {eq_reg[EW-2:0], 1'b0};
            end
        end
        if (ctrl.mul_sq)
        begin
            sq_reg <= p1[2*EW-1:16];
        end
        if (ctrl.mul_cu)
        begin
            cu_reg <= p2[EW+SQW-1:16];
        end
        if (ctrl.mul_rt)
        begin
            rt_reg <= p3[CUW+15:8];
        end
        if (ctrl.mul_dl)
        begin
            dl_reg <= p4[RTW+15:16];
        end
        if (ctrl.load_out)
        begin
            ostat_reg <= ctrl.code;
            ofrac_reg <= frac_reg;
            ooff_reg  <= off_reg;
            ofill_reg <= held_reg;
        end
    end

    assign status         = ostat_reg;
    assign blend_fraction = ofrac_reg;
    assign time_offset    = TIME_BITS'(ooff_reg);
    assign fill_count     = ofill_reg;

endmodule

// ----- hdl/api_ctrl.sv -----
module api_ctrl #(
    parameter int ESTEPS = 23
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output api_pkg::ctrl_t ctrl,
    input  api_pkg::stat_t stat
);

    import api_pkg::*;

    localparam int CW = $clog2(ESTEPS);

    typedef enum logic [4:0] {
        S_IDLE,
        S_CMD,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_DECIDE,
        S_RDJ,
        S_FIX,
        S_DIV,
        S_EN,
        S_EDIV,
        S_SQ,
        S_CU,
        S_RT,
        S_DL,
        S_ADD,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [2:0]      code_reg, code_next;
    logic            out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        code_next      = code_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctrl           = '0;
        ctrl.rsel      = RS_FIRST;
        ctrl.code      = code_reg;
        in_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.latch = 1'b1;
                    state_next = S_CMD;
                end
            end
            S_CMD:
            begin
                code_next  = ST_NORMAL;
                state_next = S_DONE;
                case (stat.cmd)
                    CMD_PUSH:
                    begin
                        if (stat.full)
                        begin
                            code_next = ST_DROP;
                        end
                        else
                        begin
                            ctrl.push = 1'b1;
                        end
                    end
                    CMD_POP:   ctrl.pop = 1'b1;
                    CMD_CLEAR: ctrl.clear = 1'b1;
                    default:
                    begin
                        if (!stat.lt2)
                        begin
                            ctrl.cap_v = 1'b1;
                            state_next = S_RD0;
                        end
                    end
                endcase
            end
            S_RD0:
            begin
                ctrl.rsel  = RS_FIRST;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                ctrl.cap_first = 1'b1;
                ctrl.rsel      = RS_NEXT;
                state_next     = S_RD2;
            end
            S_RD2:
            begin
                ctrl.cap_next = 1'b1;
                ctrl.rsel     = RS_LAST;
                state_next    = S_RD3;
            end
            S_RD3:
            begin
                ctrl.cap_last = 1'b1;
                state_next    = S_DECIDE;
            end
            S_DECIDE:
            begin
                ctrl.rsel = RS_JUMP;
                if (stat.same)
                begin
                    ctrl.pop   = 1'b1;
                    code_next  = ST_WAIT;
                    state_next = S_DONE;
                end
                else if (stat.outside)
                begin
                    if (stat.short2t)
                    begin
                        code_next  = ST_WAIT;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RDJ;
                    end
                end
                else if (stat.past_next)
                begin
                    code_next  = ST_ADVANCE;
                    state_next = S_DONE;
                end
                else
                begin
                    ctrl.div_init = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_DIV;
                end
            end
            S_RDJ:
            begin
                ctrl.cap_jump = 1'b1;
                state_next    = S_FIX;
            end
            S_FIX:
            begin
                ctrl.fix_half = stat.fix_needed;
                code_next     = ST_JUMP;
                state_next    = S_DONE;
            end
            S_DIV:
            begin
                ctrl.div_step = 1'b1;
                cnt_next      = cnt_reg + CW'(1);
                if (cnt_reg == CW'(FRAC_STEPS - 1))
                begin
                    state_next = S_EN;
                end
            end
            S_EN:
            begin
                ctrl.et_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_EDIV;
            end
            S_EDIV:
            begin
                ctrl.et_step = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                if (cnt_reg == CW'(ESTEPS - 1))
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                ctrl.mul_sq = 1'b1;
                state_next  = S_CU;
            end
            S_CU:
            begin
                ctrl.mul_cu = 1'b1;
                state_next  = S_RT;
            end
            S_RT:
            begin
                ctrl.mul_rt = 1'b1;
                state_next  = S_DL;
            end
            S_DL:
            begin
                ctrl.mul_dl = 1'b1;
                state_next  = S_ADD;
            end
            S_ADD:
            begin
                ctrl.apply = 1'b1;
                code_next  = ST_NORMAL;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctrl.load_out  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            code_reg      <= ST_NORMAL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            code_reg      <= code_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- bench/adaptive_playout_interpolator_checker.sv -----
`timescale 1ns / 100ps

module adaptive_playout_interpolator_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         command,
    input  logic [47:0]        stamp_time,
    input  logic [47:0]        wall_time,
    input  logic [15:0]        tick_step,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [2:0]         status,
    input  logic [16:0]        blend_fraction,
    input  logic [47:0]        time_offset,
    input  logic [5:0]         fill_count,
    output int                 fail_count,
    output int                 pending
);

    import api_pkg::*;

    localparam int DEPTH = 32;
    localparam longint OFS_MAX = (64'sd1 <<< 47) - 1;
    localparam longint OFS_MIN = -OFS_MAX - 1;

    typedef struct packed {
        logic [2:0]  status;
        logic [16:0] fraction;
        logic [47:0] offset;
        logic [5:0]  fill;
    } playout_result_t;

    logic [47:0] stamps [DEPTH];
    int unsigned rd_ptr;
    int unsigned held;
    longint      offset;
    logic [16:0] fraction;
    logic [15:0] gain;
    logic [4:0]  target;
    playout_result_t result_q[$];

    function automatic longint clamp_offset(longint v);
        if (v > OFS_MAX) return OFS_MAX;
        if (v < OFS_MIN) return OFS_MIN;
        return v;
    endfunction

    function automatic longint stamp_at(int unsigned k);
        return longint'({16'd0, stamps[(rd_ptr + k) % DEPTH]});
    endfunction

    function automatic logic [2:0] run_tick(longint wall, longint unsigned step);
        longint unsigned t;
        longint first, nxt, last, v, d, en;
        longint unsigned num, den, frac, m, e16, sq, cube, rate, delta;
        logic neg, before_span;
        t = (target == 0) ? 1 : target;
        if (held < 2) return ST_NORMAL;
        v = wall + offset;
        first = stamp_at(0);
        nxt = stamp_at(1);
        last = stamp_at(held - 1);
        if (first == nxt) begin
            rd_ptr = (rd_ptr + 1) % DEPTH;
            held--;
            return ST_WAIT;
        end
        if (v > last || v < first) begin
            before_span = !(v > last);
            if (held < 2 * t) return ST_WAIT;
            offset = clamp_offset(stamp_at(held - 1 - t) - wall);
            if (before_span && offset + wall < first) begin
                d = nxt - (offset + wall);
                offset = clamp_offset(offset + d / 2);
            end
            return ST_JUMP;
        end
        if (v > nxt) return ST_ADVANCE;
        num = v - first;
        den = nxt - first;
        frac = (num << 16) / den;
        en = longint'(held) * 65536 - longint'(frac) - longint'(t) * 65536;
        neg = en < 0;
        m = neg ? -en : en;
        e16 = m / t;
        sq = (e16 * e16) >> 16;
        cube = (e16 * sq) >> 16;
        rate = (cube * gain) >> 8;
        delta = (rate >> 16) * step + (((rate & 64'hFFFF) * step) >> 16);
        fraction = frac[16:0];
        offset = clamp_offset(neg ? offset - longint'(delta) : offset + longint'(delta));
        return ST_NORMAL;
    endfunction

    assign pending = result_q.size();

    always @(posedge clk or negedge rst_n) begin
        playout_result_t exp_r, got;
        logic [2:0] st;
        if (!rst_n) begin
            rd_ptr = 0;
            held = 0;
            offset = 0;
            fraction = '0;
            gain = 16'd1280;
            target = 5'd5;
            fail_count = 0;
            result_q.delete();
        end
        else begin
            if (cfg_write) begin
                if (cfg_index == CFG_GAIN) gain = cfg_data;
                else target = cfg_data[4:0];
            end
            if (out_valid && out_ready) begin
                got = '{status, blend_fraction, time_offset, fill_count};
                if (result_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end
                else begin
                    exp_r = result_q.pop_front();
                    if (got.status !== exp_r.status) begin
                        $error("status exp %0d got %0d", exp_r.status, got.status);
                        fail_count++;
                    end
                    if (got.fraction !== exp_r.fraction) begin
                        $error("blend_fraction exp %0d got %0d", exp_r.fraction, got.fraction);
                        fail_count++;
                    end
                    if (got.offset !== exp_r.offset) begin
                        $error("time_offset exp %h got %h", exp_r.offset, got.offset);
                        fail_count++;
                    end
                    if (got.fill !== exp_r.fill) begin
                        $error("fill_count exp %0d got %0d", exp_r.fill, got.fill);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                st = ST_NORMAL;
                case (command)
                    CMD_PUSH: begin
                        if (held >= DEPTH) st = ST_DROP;
                        else begin
                            stamps[(rd_ptr + held) % DEPTH] = stamp_time;
                            held++;
                        end
                    end
                    CMD_POP: begin
                        if (held != 0) begin
                            rd_ptr = (rd_ptr + 1) % DEPTH;
                            held--;
                        end
                    end
                    CMD_CLEAR: begin
                        held = 0;
                        rd_ptr = 0;
                    end
                    default: st = run_tick(longint'({16'd0, wall_time}), 64'(tick_step));
                endcase
                exp_r.status = st;
                exp_r.fraction = fraction;
                exp_r.offset = offset[47:0];
                exp_r.fill = held[5:0];
                result_q.push_back(exp_r);
            end
        end
    end

endmodule

// ----- bench/adaptive_playout_interpolator_top_tb.sv -----
`timescale 1ns / 100ps

module adaptive_playout_interpolator_top_tb;
    import api_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [47:0] stamp_time;
    logic [47:0] wall_time;
    logic [15:0] tick_step;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [16:0] blend_fraction;
    logic signed [47:0] time_offset;
    logic [5:0]  fill_count;
    int          fail_count;
    int          pending;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;

    // stream model so well-formed ticks land inside the buffered span
    longint unsigned next_stamp;
    longint unsigned frame_step;

    adaptive_playout_interpolator_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .stamp_time(stamp_time),
        .wall_time(wall_time), .tick_step(tick_step),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .blend_fraction(blend_fraction),
        .time_offset(time_offset), .fill_count(fill_count)
    );

    adaptive_playout_interpolator_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .stamp_time(stamp_time),
        .wall_time(wall_time), .tick_step(tick_step),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .blend_fraction(blend_fraction),
        .time_offset(time_offset), .fill_count(fill_count),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("adaptive_playout_interpolator_top_tb failed");
        $finish;
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n) out_ready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end
        else out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_beat(logic [1:0] cmd, logic [47:0] stamp, logic [47:0] wall,
                             logic [15:0] step);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        command <= cmd;
        stamp_time <= stamp;
        wall_time <= wall;
        tick_step <= step;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_write <= 1'b1;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain_outputs();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic push_stream(int n);
        for (int i = 0; i < n; i++)
        begin
            send_beat(CMD_PUSH, next_stamp[47:0], 48'($urandom), 16'($urandom));
            next_stamp += frame_step;
        end
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic bit u_checker_offset_guess(longint unsigned w);
        return w > 64'hFFFF_FFFF_FFFF;
    endfunction

    task automatic random_beat();
        int pick;
        longint unsigned w;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            send_beat(CMD_PUSH, next_stamp[47:0], rand48(), 16'($urandom));
            next_stamp += frame_step + $urandom_range(32'(frame_step / 4));
        end
        else if (pick < 80)
        begin
            // wall time near the stream so offset jumps then interpolation follow
            w = next_stamp - frame_step * $urandom_range(12) - $urandom_range(32'(frame_step));
            if (u_checker_offset_guess(w)) w = next_stamp;
            send_beat(CMD_TICK, rand48(), w[47:0] - 48'(time_offset), 16'($urandom));
        end
        else if (pick < 90) send_beat(CMD_POP, rand48(), rand48(), 16'($urandom));
        else if (pick < 92) send_beat(CMD_CLEAR, rand48(), rand48(), 16'($urandom));
        else if (pick < 96) send_beat(CMD_PUSH, rand48(), rand48(), 16'($urandom));
        else send_beat(CMD_TICK, rand48(), rand48(), 16'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_GAIN;
        cfg_data = '0;
        in_valid = 1'b0;
        command = CMD_PUSH;
        stamp_time = '0;
        wall_time = '0;
        tick_step = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        next_stamp = 64'h0000_0010_0000;
        frame_step = 64'h0000_0000_0444;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed
        send_beat(CMD_TICK, '0, '0, '0);
        send_beat(CMD_POP, '0, '0, '0);
        send_beat(CMD_PUSH, 48'h1000, '0, '0);
        send_beat(CMD_PUSH, 48'h1000, '0, '0);
        send_beat(CMD_TICK, '0, 48'h1000, 16'hFFFF);
        send_beat(CMD_PUSH, 48'h2000, '0, '0);
        send_beat(CMD_TICK, '0, 48'h1800, 16'h0444);
        send_beat(CMD_TICK, '0, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
        send_beat(CMD_TICK, '0, '0, 16'h0444);
        send_beat(CMD_CLEAR, '0, '0, '0);
        push_stream(12);
        send_beat(CMD_TICK, '0, '0, 16'h0444);
        send_beat(CMD_TICK, '0, 48'hFFFF_FFFF_FFFF, 16'h0444);
        send_beat(CMD_TICK, '0, next_stamp[47:0] - 48'(time_offset) - 48'h2000, 16'hFFFF);
        push_stream(22);
        send_beat(CMD_PUSH, 48'hFFFF_FFFF_FFFF, '0, '0);
        send_beat(CMD_TICK, 48'hFFFF_FFFF_FFFF, 48'h5555_5555_5555, 16'h8000);
        send_beat(CMD_CLEAR, '0, '0, '0);
        drain_outputs();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin write_reg(CFG_GAIN, 16'd0); write_reg(CFG_FILL, 16'd0); end
                1: begin write_reg(CFG_GAIN, 16'hFFFF); write_reg(CFG_FILL, 16'd16); end
                2: begin write_reg(CFG_GAIN, 16'd1280); write_reg(CFG_FILL, 16'd1); end
                3: begin write_reg(CFG_GAIN, 16'($urandom)); write_reg(CFG_FILL, 16'd3); end
                4: begin write_reg(CFG_GAIN, 16'h0100); write_reg(CFG_FILL, 16'd31); end
                default: begin write_reg(CFG_GAIN, 16'd1280); write_reg(CFG_FILL, 16'd5); end
            endcase
            send_idle_pct = (phase == 1 || phase == 4) ? 58 : (phase == 3 ? 17 : 0);
            recv_stall_pct = (phase == 2 || phase == 4) ? 58 : (phase == 3 ? 17 : 0);
            frame_step = 64'($urandom_range(16'hFFFF, 16'h0100));
            if (phase == 5)
            begin
                @(negedge clk);
                hold_off_cycles = 400;
            end
            for (int i = 0; i < 100; i++) random_beat();
            drain_outputs();
        end

        if (fail_count == 0)
            $display("adaptive_playout_interpolator_top_tb passed");
        else
            $display("adaptive_playout_interpolator_top_tb failed");
        $finish;
    end

endmodule
